/* hdl/ntp_timestamp_to_local_date_assert.svh */
// ---------------------------------------------------------------------------
// NTP timestamp to local date: assertion macros
// Shared concurrent assertion forms; they compile to nothing under ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef NTP_TIMESTAMP_TO_LOCAL_DATE_ASSERT_SVH
`define NTP_TIMESTAMP_TO_LOCAL_DATE_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define NTD_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntd: next-cycle check failed");

`else

`define NTD_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons)
`define NTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/ntd_pkg.sv */
// ---------------------------------------------------------------------------
// NTP timestamp to local date: package
// Constants, reciprocal multipliers, calendar helpers and the structs that
// carry an item between the pipeline sections.
// ---------------------------------------------------------------------------
package ntd_pkg;

    // Number of register stages from the input register to the result register.
    localparam int STAGES = 12;

    // Seconds from 1900-01-01 to 1970-01-01.
    localparam logic [31:0] EPOCH_OFFSET = 32'h83aa7e80;
    localparam logic [32:0] SECS_PER_DAY = 33'd86400;

    // Zone selection: index 24 is UTC, each step is 30 minutes.
    localparam logic [5:0]  ZONE_UTC      = 6'd24;
    localparam logic [5:0]  ZONE_MAX      = 6'd48;
    localparam logic [11:0] ZONE_STEP_MIN = 12'd30;
    localparam logic [11:0] ZONE_BIAS     = 12'd720;
    localparam logic [11:0] MIN_PER_DAY   = 12'd1440;

    // Civil date constants (days counted from 0000-03-01).
    localparam logic [19:0] DAYS_TO_1970  = 20'd719468;
    localparam logic [19:0] ERA4_START    = 20'd584388;
    localparam logic [19:0] ERA5_START    = 20'd730485;
    localparam logic [17:0] DAYS_CENT_1   = 18'd36524;
    localparam logic [17:0] DAYS_CENT_2   = 18'd73048;
    localparam logic [17:0] DAYS_CENT_3   = 18'd109572;
    localparam logic [17:0] DAYS_ERA_LAST = 18'd146096;
    localparam logic [17:0] DAYS_PER_YEAR = 18'd365;
    localparam logic [11:0] YEAR_ERA4     = 12'd1600;
    localparam logic [11:0] YEAR_ERA5     = 12'd2000;
    localparam logic [11:0] BASE_YEAR     = 12'd2000;
    // The one century year in range that is not a leap year.
    localparam logic [11:0] YEAR_NO_LEAP  = 12'd2100;

    // Microsecond approximation terms.
    localparam logic [22:0] USEC_ROUND = 23'd32768;
    localparam logic [16:0] USEC_CORR  = 17'd759;

    // Exact reciprocals: floor(x / d) = (x * ceil(2^k / d)) >> k for the
    // operand widths used here, with 2^k >= d * 2^(operand width).
    localparam int SH_DAY   = 35;
    localparam logic [25:0] RCP_DAY   = 26'(((64'd1 << SH_DAY) + 64'd674) / 64'd675);
    localparam int SH_MIN   = 23;
    localparam logic [17:0] RCP_MIN   = 18'(((64'd1 << SH_MIN) + 64'd59) / 64'd60);
    localparam int SH_Y4    = 29;
    localparam logic [18:0] RCP_Y4    = 19'(((64'd1 << SH_Y4) + 64'd1459) / 64'd1460);
    localparam int SH_YEAR  = 27;
    localparam logic [18:0] RCP_YEAR  = 19'(((64'd1 << SH_YEAR) + 64'd364) / 64'd365);
    localparam int SH_MONTH = 19;
    localparam logic [11:0] RCP_MONTH = 12'(((64'd1 << SH_MONTH) + 64'd152) / 64'd153);
    localparam int SH_HOUR  = 17;
    localparam logic [11:0] RCP_HOUR  = 12'(((64'd1 << SH_HOUR) + 64'd59) / 64'd60);

    // Load enables, one per pipeline stage.
    typedef struct packed {
        logic [STAGES-1:0] load;
    } t_pipe_ctl;

    // Item leaving the epoch section.
    typedef struct packed {
        logic [17:0] doe;
        logic        era5;
        logic [17:0] yn;
        logic [5:0]  sec;
        logic [11:0] lraw;
        logic [19:0] usec;
    } t_epoch_res;

    // Item leaving the civil date section (UTC date).
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [5:0]  sec;
        logic [11:0] lraw;
        logic [19:0] usec;
    } t_civil_res;

    // Day of the March-based year on which month index mp starts.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        begin
            case (mp)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd61;
                4'd3:    d = 9'd92;
                4'd4:    d = 9'd122;
                4'd5:    d = 9'd153;
                4'd6:    d = 9'd184;
                4'd7:    d = 9'd214;
                4'd8:    d = 9'd245;
                4'd9:    d = 9'd275;
                4'd10:   d = 9'd306;
                4'd11:   d = 9'd337;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

    // Length of a month; valid for years from 1970 to 2107.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
        logic       leap;
        logic [4:0] len;
        begin
            leap = (y[1:0] == 2'b00) && (y != YEAR_NO_LEAP);
            case (m)
                4'd2:                     len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
                default:                  len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

/* hdl/ntd_epoch.sv */
// ---------------------------------------------------------------------------
// NTP timestamp to local date: epoch section
// Stages 0 to 4. Removes the 1970 offset, splits seconds into days and
// second of day, starts the civil date arithmetic and forms microseconds.
// ---------------------------------------------------------------------------
module ntd_epoch (
    input  logic                i_clk,
    input  ntd_pkg::t_pipe_ctl  i_ctl,
    input  logic [31:0]         i_ntp_seconds,
    input  logic [31:0]         i_ntp_fraction,
    input  logic [5:0]          i_zone_index,
    output ntd_pkg::t_epoch_res o_res
);
    import ntd_pkg::*;

    // Stage 0: input register.
    logic [31:0] r_s0_secs, n_s0_secs;
    logic [31:0] r_s0_frac;
    logic [5:0]  r_s0_zone, n_s0_zone;

    assign n_s0_secs = i_ntp_seconds - EPOCH_OFFSET;
    assign n_s0_zone = (i_zone_index > ZONE_MAX) ? ZONE_MAX : i_zone_index;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_s0_secs <= n_s0_secs;
            r_s0_frac <= i_ntp_fraction;
            r_s0_zone <= n_s0_zone;
        end
    end

    // Stage 1: whole days, and the rounding term of the microsecond formula.
    logic [50:0] w_day_prod;
    logic [15:0] r_s1_days, n_s1_days;
    logic [6:0]  r_s1_ut, n_s1_ut;
    logic [31:0] r_s1_secs;
    logic [19:0] r_s1_frac20;
    logic [5:0]  r_s1_zone;

    assign w_day_prod = 51'(r_s0_secs[31:7]) * 51'(RCP_DAY);
    assign n_s1_days  = 16'(w_day_prod >> SH_DAY);
    assign n_s1_ut    = 7'((23'(r_s0_frac[31:10]) + USEC_ROUND) >> 16);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_s1_days   <= n_s1_days;
            r_s1_ut     <= n_s1_ut;
            r_s1_secs   <= r_s0_secs;
            r_s1_frac20 <= r_s0_frac[31:12];
            r_s1_zone   <= r_s0_zone;
        end
    end

    // Stage 2: second of day, day of the 400-year era, microseconds.
    logic [32:0] w_day_secs;
    logic [19:0] w_z;
    logic [16:0] w_corr;
    logic [16:0] r_s2_sod, n_s2_sod;
    logic [17:0] r_s2_doe, n_s2_doe;
    logic        r_s2_era5, n_s2_era5;
    logic [19:0] r_s2_usec, n_s2_usec;
    logic [5:0]  r_s2_zone;

    assign w_day_secs = 33'(r_s1_days) * SECS_PER_DAY;
    assign n_s2_sod   = 17'(r_s1_secs - w_day_secs[31:0]);
    assign w_z        = 20'(r_s1_days) + DAYS_TO_1970;
    assign n_s2_era5  = (w_z >= ERA5_START);
    assign n_s2_doe   = 18'(w_z - (n_s2_era5 ? ERA5_START : ERA4_START));
    assign w_corr     = 17'(r_s1_ut) * USEC_CORR;
    assign n_s2_usec  = r_s1_frac20 - 20'(w_corr);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_s2_sod  <= n_s2_sod;
            r_s2_doe  <= n_s2_doe;
            r_s2_era5 <= n_s2_era5;
            r_s2_usec <= n_s2_usec;
            r_s2_zone <= r_s1_zone;
        end
    end

    // Stage 3: minute of day and the leap-cycle quotients of the era day.
    logic [34:0] w_mod_prod;
    logic [36:0] w_q4_prod;
    logic [10:0] r_s3_mod, n_s3_mod;
    logic [6:0]  r_s3_q4, n_s3_q4;
    logic [2:0]  r_s3_q100, n_s3_q100;
    logic        r_s3_q400, n_s3_q400;
    logic [16:0] r_s3_sod;
    logic [17:0] r_s3_doe;
    logic        r_s3_era5;
    logic [19:0] r_s3_usec;
    logic [5:0]  r_s3_zone;

    assign w_mod_prod = 35'(r_s2_sod) * 35'(RCP_MIN);
    assign n_s3_mod   = 11'(w_mod_prod >> SH_MIN);
    assign w_q4_prod  = 37'(r_s2_doe) * 37'(RCP_Y4);
    assign n_s3_q4    = 7'(w_q4_prod >> SH_Y4);
    assign n_s3_q100  = 3'(r_s2_doe >= DAYS_CENT_1) + 3'(r_s2_doe >= DAYS_CENT_2)
                      + 3'(r_s2_doe >= DAYS_CENT_3) + 3'(r_s2_doe >= DAYS_ERA_LAST);
    assign n_s3_q400  = (r_s2_doe == DAYS_ERA_LAST);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_s3_mod  <= n_s3_mod;
            r_s3_q4   <= n_s3_q4;
            r_s3_q100 <= n_s3_q100;
            r_s3_q400 <= n_s3_q400;
            r_s3_sod  <= r_s2_sod;
            r_s3_doe  <= r_s2_doe;
            r_s3_era5 <= r_s2_era5;
            r_s3_usec <= r_s2_usec;
            r_s3_zone <= r_s2_zone;
        end
    end

    // Stage 4: year numerator, second of minute and the biased local minute.
    logic [16:0] w_mod_secs;
    logic [11:0] w_zone_min;
    logic [17:0] r_s4_yn, n_s4_yn;
    logic [5:0]  r_s4_sec, n_s4_sec;
    logic [11:0] r_s4_lraw, n_s4_lraw;
    logic [17:0] r_s4_doe;
    logic        r_s4_era5;
    logic [19:0] r_s4_usec;

    assign n_s4_yn    = r_s3_doe - 18'(r_s3_q4) + 18'(r_s3_q100) - 18'(r_s3_q400);
    assign w_mod_secs = 17'(r_s3_mod) * 17'd60;
    assign n_s4_sec   = 6'(r_s3_sod - w_mod_secs);
    assign w_zone_min = 12'(r_s3_zone) * ZONE_STEP_MIN;
    assign n_s4_lraw  = 12'(r_s3_mod) + w_zone_min;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_s4_yn   <= n_s4_yn;
            r_s4_sec  <= n_s4_sec;
            r_s4_lraw <= n_s4_lraw;
            r_s4_doe  <= r_s3_doe;
            r_s4_era5 <= r_s3_era5;
            r_s4_usec <= r_s3_usec;
        end
    end

    assign o_res.doe  = r_s4_doe;
    assign o_res.era5 = r_s4_era5;
    assign o_res.yn   = r_s4_yn;
    assign o_res.sec  = r_s4_sec;
    assign o_res.lraw = r_s4_lraw;
    assign o_res.usec = r_s4_usec;

endmodule

/* hdl/ntd_civil.sv */
// ---------------------------------------------------------------------------
// NTP timestamp to local date: civil date section
// Stages 5 to 8. Turns the day of the era into UTC year, month and day.
// ---------------------------------------------------------------------------
module ntd_civil (
    input  logic                i_clk,
    input  ntd_pkg::t_pipe_ctl  i_ctl,
    input  ntd_pkg::t_epoch_res i_res,
    output ntd_pkg::t_civil_res o_res
);
    import ntd_pkg::*;

    // Stage 5: year of the era.
    logic [36:0] w_yoe_prod;
    logic [8:0]  r_s5_yoe, n_s5_yoe;
    logic [17:0] r_s5_doe;
    logic        r_s5_era5;
    logic [5:0]  r_s5_sec;
    logic [11:0] r_s5_lraw;
    logic [19:0] r_s5_usec;

    assign w_yoe_prod = 37'(i_res.yn) * 37'(RCP_YEAR);
    assign n_s5_yoe   = 9'(w_yoe_prod >> SH_YEAR);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r_s5_yoe  <= n_s5_yoe;
            r_s5_doe  <= i_res.doe;
            r_s5_era5 <= i_res.era5;
            r_s5_sec  <= i_res.sec;
            r_s5_lraw <= i_res.lraw;
            r_s5_usec <= i_res.usec;
        end
    end

    // Stage 6: day of the March-based year, and the year before the
    // January/February correction.
    logic [17:0] w_yoe_days;
    logic [1:0]  w_c100;
    logic [17:0] w_ydays;
    logic [8:0]  r_s6_doy, n_s6_doy;
    logic [11:0] r_s6_ybase, n_s6_ybase;
    logic [5:0]  r_s6_sec;
    logic [11:0] r_s6_lraw;
    logic [19:0] r_s6_usec;

    assign w_yoe_days = 18'(r_s5_yoe) * DAYS_PER_YEAR;
    assign w_c100     = 2'(r_s5_yoe >= 9'd100) + 2'(r_s5_yoe >= 9'd200)
                      + 2'(r_s5_yoe >= 9'd300);
    assign w_ydays    = w_yoe_days + 18'(r_s5_yoe[8:2]) - 18'(w_c100);
    assign n_s6_doy   = 9'(r_s5_doe - w_ydays);
    assign n_s6_ybase = 12'(r_s5_yoe) + (r_s5_era5 ? YEAR_ERA5 : YEAR_ERA4);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[6]) begin
            r_s6_doy   <= n_s6_doy;
            r_s6_ybase <= n_s6_ybase;
            r_s6_sec   <= r_s5_sec;
            r_s6_lraw  <= r_s5_lraw;
            r_s6_usec  <= r_s5_usec;
        end
    end

    // Stage 7: month index counted from March.
    logic [10:0] w_mp_num;
    logic [22:0] w_mp_prod;
    logic [3:0]  r_s7_mp, n_s7_mp;
    logic [8:0]  r_s7_doy;
    logic [11:0] r_s7_ybase;
    logic [5:0]  r_s7_sec;
    logic [11:0] r_s7_lraw;
    logic [19:0] r_s7_usec;

    assign w_mp_num  = 11'(r_s6_doy) * 11'd5 + 11'd2;
    assign w_mp_prod = 23'(w_mp_num) * 23'(RCP_MONTH);
    assign n_s7_mp   = 4'(w_mp_prod >> SH_MONTH);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[7]) begin
            r_s7_mp    <= n_s7_mp;
            r_s7_doy   <= r_s6_doy;
            r_s7_ybase <= r_s6_ybase;
            r_s7_sec   <= r_s6_sec;
            r_s7_lraw  <= r_s6_lraw;
            r_s7_usec  <= r_s6_usec;
        end
    end

    // Stage 8: day of month, calendar month and UTC year.
    logic [4:0]  r_s8_day, n_s8_day;
    logic [3:0]  r_s8_month, n_s8_month;
    logic [11:0] r_s8_year, n_s8_year;
    logic [5:0]  r_s8_sec;
    logic [11:0] r_s8_lraw;
    logic [19:0] r_s8_usec;

    assign n_s8_day   = 5'(r_s7_doy - month_start(r_s7_mp) + 9'd1);
    assign n_s8_month = (r_s7_mp < 4'd10) ? r_s7_mp + 4'd3 : r_s7_mp - 4'd9;
    assign n_s8_year  = r_s7_ybase + 12'(n_s8_month <= 4'd2);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[8]) begin
            r_s8_day   <= n_s8_day;
            r_s8_month <= n_s8_month;
            r_s8_year  <= n_s8_year;
            r_s8_sec   <= r_s7_sec;
            r_s8_lraw  <= r_s7_lraw;
            r_s8_usec  <= r_s7_usec;
        end
    end

    assign o_res.day   = r_s8_day;
    assign o_res.month = r_s8_month;
    assign o_res.year  = r_s8_year;
    assign o_res.sec   = r_s8_sec;
    assign o_res.lraw  = r_s8_lraw;
    assign o_res.usec  = r_s8_usec;

endmodule

/* hdl/ntd_zone.sv */
// ---------------------------------------------------------------------------
// NTP timestamp to local date: zone section
// Stages 9 to 11. Applies the zone shift with day, month and year carry or
// borrow, splits the local minute of day and builds the result item.
// ---------------------------------------------------------------------------
module ntd_zone (
    input  logic                i_clk,
    input  ntd_pkg::t_pipe_ctl  i_ctl,
    input  ntd_pkg::t_civil_res i_res,
    output logic [55:0]         o_tdata,
    output logic                o_tuser
);
    import ntd_pkg::*;

    // Stage 9: zone shift across midnight.
    logic [3:0]  w_prev_month;
    logic [11:0] w_prev_year;
    logic [4:0]  w_len_cur;
    logic [4:0]  w_len_prev;
    logic [10:0] r_s9_lmin, n_s9_lmin;
    logic [4:0]  r_s9_day, n_s9_day;
    logic [3:0]  r_s9_month, n_s9_month;
    logic [11:0] r_s9_year, n_s9_year;
    logic        r_s9_ok, n_s9_ok;
    logic [5:0]  r_s9_sec;
    logic [19:0] r_s9_usec;

    assign w_prev_month = (i_res.month == 4'd1) ? 4'd12 : i_res.month - 4'd1;
    assign w_prev_year  = (i_res.month == 4'd1) ? i_res.year - 12'd1 : i_res.year;
    assign w_len_cur    = month_len(i_res.month, i_res.year);
    assign w_len_prev   = month_len(w_prev_month, w_prev_year);

    always_comb begin
        n_s9_day   = i_res.day;
        n_s9_month = i_res.month;
        n_s9_year  = i_res.year;
        n_s9_lmin  = 11'(i_res.lraw - ZONE_BIAS);
        priority if (i_res.lraw >= ZONE_BIAS + MIN_PER_DAY) begin
            // Next day; past the month's last day, restart at the first of the next month.
            n_s9_lmin = 11'(i_res.lraw - (ZONE_BIAS + MIN_PER_DAY));
            if (i_res.day >= w_len_cur) begin
                n_s9_day = 5'd1;
                if (i_res.month == 4'd12) begin
                    n_s9_month = 4'd1;
                    n_s9_year  = i_res.year + 12'd1;
                end else begin
                    n_s9_month = i_res.month + 4'd1;
                end
            end else begin
                n_s9_day = i_res.day + 5'd1;
            end
        end else if (i_res.lraw < ZONE_BIAS) begin
            // Previous day; from the first, go back to the last day of the previous month.
            n_s9_lmin = 11'(i_res.lraw + ZONE_BIAS);
            if (i_res.day == 5'd1) begin
                n_s9_month = w_prev_month;
                n_s9_year  = w_prev_year;
                n_s9_day   = w_len_prev;
            end else begin
                n_s9_day = i_res.day - 5'd1;
            end
        end else begin
            n_s9_lmin = 11'(i_res.lraw - ZONE_BIAS);
        end
    end

    // Both the UTC and the local year must be 2000 or later.
    assign n_s9_ok = (i_res.year >= BASE_YEAR) && (n_s9_year >= BASE_YEAR);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[9]) begin
            r_s9_lmin  <= n_s9_lmin;
            r_s9_day   <= n_s9_day;
            r_s9_month <= n_s9_month;
            r_s9_year  <= n_s9_year;
            r_s9_ok    <= n_s9_ok;
            r_s9_sec   <= i_res.sec;
            r_s9_usec  <= i_res.usec;
        end
    end

    // Stage 10: local hour.
    logic [22:0] w_hour_prod;
    logic [4:0]  r_s10_hour, n_s10_hour;
    logic [10:0] r_s10_lmin;
    logic [4:0]  r_s10_day;
    logic [3:0]  r_s10_month;
    logic [11:0] r_s10_year;
    logic        r_s10_ok;
    logic [5:0]  r_s10_sec;
    logic [19:0] r_s10_usec;

    assign w_hour_prod = 23'(r_s9_lmin) * 23'(RCP_HOUR);
    assign n_s10_hour  = 5'(w_hour_prod >> SH_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[10]) begin
            r_s10_hour  <= n_s10_hour;
            r_s10_lmin  <= r_s9_lmin;
            r_s10_day   <= r_s9_day;
            r_s10_month <= r_s9_month;
            r_s10_year  <= r_s9_year;
            r_s10_ok    <= r_s9_ok;
            r_s10_sec   <= r_s9_sec;
            r_s10_usec  <= r_s9_usec;
        end
    end

    // Stage 11: result register; an item before 2000 is all zeros.
    logic [10:0] w_hour_min;
    logic [5:0]  w_minute;
    logic [6:0]  w_yoff;
    logic [55:0] r_s11_tdata, n_s11_tdata;
    logic        r_s11_tuser;

    assign w_hour_min  = 11'(r_s10_hour) * 11'd60;
    assign w_minute    = 6'(r_s10_lmin - w_hour_min);
    assign w_yoff      = 7'(r_s10_year - BASE_YEAR);
    assign n_s11_tdata = r_s10_ok ? {3'b000, r_s10_usec, r_s10_sec, w_minute, r_s10_hour,
                                     r_s10_day, r_s10_month, w_yoff} : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[11]) begin
            r_s11_tdata <= n_s11_tdata;
            r_s11_tuser <= r_s10_ok;
        end
    end

    assign o_tdata = r_s11_tdata;
    assign o_tuser = r_s11_tuser;

endmodule

/* hdl/ntp_timestamp_to_local_date.sv */
// ---------------------------------------------------------------------------
// NTP timestamp to local date
// Takes one NTP transmit timestamp per item (tdata bits 31:0 whole seconds
// since 1900, bits 63:32 the 32-bit fraction) and returns one result item
// with the local civil date and time: UTC as gmtime gives it, shifted by the
// zone held in the zone register (0 is UTC-12:00, each step 30 minutes, 24 is
// UTC, 48 is UTC+12:00; larger values act as 48; reset value 24). Stamps
// before 1970 wrap to 2036..2106. tuser is 1 when both the UTC and the local
// year are 2000 or later; otherwise the whole tdata is zero. Microseconds use
// the shift-and-multiply approximation of the fraction. The datapath is a
// 12-stage pipeline; one item can be taken every cycle while the output is
// not held. Each stage holds its item until the next stage frees, so input
// items are still taken while a result waits at the output, until every
// stage is full. Write the zone register only while no item is in flight.
// ---------------------------------------------------------------------------
`include "ntp_timestamp_to_local_date_assert.svh"

module ntp_timestamp_to_local_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Zone register write port.
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    // Input items. tdata: [31:0] ntp_seconds, [63:32] ntp_fraction.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // Result items. tdata: [6:0] year_offset, [10:7] month_num, [15:11] day_num,
    // [20:16] hour_num, [26:21] minute_num, [32:27] second_num,
    // [52:33] micro_num, [55:53] zero.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,
    // tuser: [0] valid_res.
    output logic        m_axis_tuser
);
    import ntd_pkg::*;

    // Zone register.
    logic [5:0] r_zone_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_index <= ZONE_UTC;
        end else if (i_cfg_we) begin
            r_zone_index <= i_cfg_wdata;
        end
    end

    // Pipeline occupancy: a stage loads when it is empty or its item moves on.
    t_pipe_ctl         ctl;
    logic [STAGES-1:0] r_vld, n_vld;

    always_comb begin
        ctl.load[STAGES-1] = !r_vld[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            ctl.load[k] = !r_vld[k] || ctl.load[k+1];
        end
    end

    assign n_vld = {r_vld[STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (ctl.load & n_vld) | (~ctl.load & r_vld);
        end
    end

    assign s_axis_tready = ctl.load[0];
    assign m_axis_tvalid = r_vld[STAGES-1];

    // Datapath sections.
    t_epoch_res epoch_res;
    t_civil_res civil_res;

    ntd_epoch u_epoch (
        .i_clk          (i_clk),
        .i_ctl          (ctl),
        .i_ntp_seconds  (s_axis_tdata[31:0]),
        .i_ntp_fraction (s_axis_tdata[63:32]),
        .i_zone_index   (r_zone_index),
        .o_res          (epoch_res)
    );

    ntd_civil u_civil (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_res (epoch_res),
        .o_res (civil_res)
    );

    ntd_zone u_zone (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_res   (civil_res),
        .o_tdata (m_axis_tdata),
        .o_tuser (m_axis_tuser)
    );

    // Checks.
    `NTD_ASSERT_HOLDS(a_ready_when_out_empty, i_clk, i_rst_n,
        !m_axis_tvalid, s_axis_tready)
    `NTD_ASSERT_HOLDS(a_invalid_is_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
    `NTD_ASSERT_HOLDS(a_fields_in_range, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser,
        (m_axis_tdata[6:0] <= 7'd106) && (m_axis_tdata[10:7] >= 4'd1) &&
        (m_axis_tdata[10:7] <= 4'd12) && (m_axis_tdata[15:11] >= 5'd1) &&
        (m_axis_tdata[20:16] <= 5'd23) && (m_axis_tdata[26:21] <= 6'd59) &&
        (m_axis_tdata[32:27] <= 6'd59) && (m_axis_tdata[52:33] <= 20'd999999))
    `NTD_ASSERT_NEXT(a_no_repeat, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !r_vld[STAGES-2], !m_axis_tvalid)

endmodule

/* sim/ntp_timestamp_to_local_date_test.sv */
// ---------------------------------------------------------------------------
// NTP timestamp to local date: block-level test
// Drives NTP timestamps into the stream input under several zone settings.
// Each accepted item is turned into the expected local date and time by an
// independent calendar predictor. Every result item is checked field by field,
// in order, against those predictions. The sender works in bursts with random
// gaps, and the receiver stalls on its own pattern. One long receiver hold-off
// fills the pipeline so that the input has to stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntp_timestamp_to_local_date_test;

    import ntd_pkg::*;

    localparam logic [5:0] ZONE_WEST_END = 6'd0;   // UTC-12:00
    localparam logic [5:0] ZONE_ALL_ONES = 6'h3F;  // above the table, acts as +12:00
    localparam int         ZONE_STEP     = 30;     // minutes per zone step
    localparam int         STALL_LIMIT   = 3000;   // cycles with no item moving
    localparam int         LONG_HOLD     = 300;    // receiver hold-off in cycles
    localparam int         DRAIN_CYCLES  = 16;    // a little beyond the latency

    // Result tdata layout, most significant field first.
    typedef struct packed {
        logic [2:0]  pad;
        logic [19:0] micro;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [6:0]  year;
    } t_date_word;

    typedef struct packed {
        logic       valid;
        t_date_word word;
    } t_local_date;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    t_local_date dates_due[$];
    logic [5:0]  zone_setting;
    int          error_count = 0;
    int          idle_cycles;
    bit          sink_choppy;
    int          sink_hold;

    ntp_timestamp_to_local_date dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock, 20 ns period.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Full Gregorian month length.
    function automatic int days_in_month(input int m, input int y);
        bit leap;
        begin
            leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
            if (m == 2)
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        end
    endfunction

    // NTP whole seconds for a UTC civil date and time, modulo 2^32.
    function automatic logic [31:0] stamp_of(input int y, input int m, input int d,
                                             input int hh, input int mm, input int ss);
        int     yy;
        int     era;
        int     yoe;
        int     doy;
        int     doe;
        int     days;
        longint total;
        begin
            yy    = (m <= 2) ? y - 1 : y;
            era   = yy / 400;
            yoe   = yy - era * 400;
            doy   = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
            doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days  = era * 146097 + doe - 719468;
            total = longint'(days) * 86400 + hh * 3600 + mm * 60 + ss
                    + longint'({32'd0, EPOCH_OFFSET});
            return total[31:0];
        end
    endfunction

    // Expected result for one timestamp under the given zone register value.
    function automatic t_local_date predict_local_date(input logic [31:0] ntp_secs,
                                                       input logic [31:0] ntp_frac,
                                                       input logic [5:0]  zone_reg);
        t_local_date r;
        logic [31:0] unix_secs;
        int unsigned day_count;
        int unsigned sec_of_day;
        int unsigned shifted;
        int unsigned era;
        int unsigned doe;
        int unsigned yoe;
        int unsigned doy;
        int unsigned mp;
        int unsigned frac;
        int unsigned usec;
        int          year;
        int          month;
        int          day;
        int          zone;
        int          local_min;
        begin
            r          = '0;
            unix_secs  = ntp_secs - EPOCH_OFFSET;
            zone       = (zone_reg > ZONE_MAX) ? int'(ZONE_MAX) : int'(zone_reg);
            day_count  = unix_secs / 86400;
            sec_of_day = unix_secs % 86400;

            // Days since 1970 to a March-based civil date.
            shifted = day_count + 719468;
            era     = shifted / 146097;
            doe     = shifted - era * 146097;
            yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp      = (5 * doy + 2) / 153;
            day     = int'(doy - (153 * mp + 2) / 5 + 1);
            month   = (mp < 10) ? int'(mp) + 3 : int'(mp) - 9;
            year    = int'(yoe + era * 400) + ((month <= 2) ? 1 : 0);

            frac = ntp_frac;
            usec = ((frac >> 12) - 759 * (((frac >> 10) + 32768) >> 16)) & 32'hF_FFFF;

            if (year < int'(BASE_YEAR))
                return r;

            // Shift the minute of day by the zone and carry into the date.
            local_min = int'(sec_of_day / 60) + (zone - int'(ZONE_UTC)) * ZONE_STEP;
            if (local_min >= int'(MIN_PER_DAY)) begin
                local_min -= int'(MIN_PER_DAY);
                day += 1;
                if (day > days_in_month(month, year)) begin
                    day = 1;
                    if (month == 12) begin
                        month = 1;
                        year += 1;
                    end else begin
                        month += 1;
                    end
                end
            end else if (local_min < 0) begin
                local_min += int'(MIN_PER_DAY);
                day -= 1;
                if (day < 1) begin
                    if (month == 1) begin
                        month = 12;
                        year -= 1;
                    end else begin
                        month -= 1;
                    end
                    day = days_in_month(month, year);
                end
            end

            if (year < int'(BASE_YEAR))
                return r;

            r.valid       = 1'b1;
            r.word.year   = 7'(year - int'(BASE_YEAR));
            r.word.month  = 4'(month);
            r.word.day    = 5'(day);
            r.word.hour   = 5'(local_min / 60);
            r.word.minute = 6'(local_min % 60);
            r.word.second = 6'(sec_of_day % 60);
            r.word.micro  = 20'(usec);
            return r;
        end
    endfunction

    // One line per mismatch, and a count.
    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    // Offer one timestamp item and record its prediction once it is taken.
    task automatic send_stamp(input logic [31:0] secs, input logic [31:0] frac);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {frac, secs};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        dates_due.push_back(predict_local_date(secs, frac, zone_setting));
    endtask

    // Leave the input idle for a number of cycles.
    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1)
            @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (dates_due.size() != 0)
            @(posedge i_clk);
        repeat (4)
            @(posedge i_clk);
    endtask

    // Write the zone register; only called with nothing in flight.
    task automatic set_zone(input logic [5:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        zone_setting = value;
    endtask

    // Random stamp: plain 32-bit values, or dates near month and day edges.
    task automatic send_random_stamp();
        logic [31:0] secs;
        logic [31:0] frac;
        int          y;
        int          m;
        int          d;
        begin
            y = $urandom_range(2106, 1999);
            m = $urandom_range(12, 1);
            d = $urandom_range(1, 0) ? 1 : days_in_month(m, y);
            case ($urandom_range(3, 0))
                0, 1: secs = $urandom();
                2: secs = stamp_of(y, m, d, $urandom_range(23, 0),
                                   $urandom_range(59, 0), $urandom_range(59, 0));
                default: secs = stamp_of(y, m, d, $urandom_range(1, 0) ? 23 : 0,
                                         $urandom_range(59, 0), $urandom_range(59, 0));
            endcase
            case ($urandom_range(7, 0))
                0: frac = 32'h0000_0000;
                1: frac = 32'hFFFF_FFFF;
                default: frac = $urandom();
            endcase
            send_stamp(secs, frac);
        end
    endtask

    // Straight after reset: the zone register must read as UTC.
    task automatic test_utc_edges();
        send_stamp(32'h0000_0000, 32'h0000_0000);
        send_stamp(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_stamp(EPOCH_OFFSET, 32'h8000_0000);
        send_stamp(stamp_of(1999, 12, 31, 23, 59, 59), 32'h0000_0FFF);
        send_stamp(stamp_of(2000, 1, 1, 0, 0, 0), 32'hFFFF_F000);
        send_stamp(stamp_of(2000, 2, 29, 12, 30, 45), 32'h1234_5678);
        send_stamp(stamp_of(2100, 2, 28, 23, 59, 59), 32'hAAAA_AAAA);
        send_stamp(stamp_of(2106, 2, 7, 6, 28, 15), 32'h5555_5555);
        drain_results();
    endtask

    // Day, month and year carries in both directions.
    task automatic test_zone_rollovers();
        set_zone(ZONE_MAX);
        send_stamp(stamp_of(2000, 1, 31, 12, 0, 0), 32'h0000_0001);
        send_stamp(stamp_of(2000, 2, 28, 12, 0, 0), 32'h7FFF_FFFF);
        send_stamp(stamp_of(2100, 2, 28, 13, 0, 0), 32'hDEAD_BEEF);
        send_stamp(stamp_of(2099, 12, 31, 18, 0, 0), 32'h0001_0000);
        send_stamp(32'hFFFF_FFFF, 32'h0000_0000);
        drain_results();
        set_zone(ZONE_WEST_END);
        send_stamp(stamp_of(2000, 1, 1, 6, 0, 0), 32'hFFFF_FFFF);
        send_stamp(stamp_of(2000, 3, 1, 3, 0, 0), 32'h3333_3333);
        send_stamp(stamp_of(2001, 3, 1, 3, 0, 0), 32'hCCCC_CCCC);
        send_stamp(stamp_of(2010, 1, 1, 0, 0, 0), 32'h0F0F_0F0F);
        send_stamp(stamp_of(2010, 5, 1, 11, 59, 59), 32'hF0F0_F0F0);
        drain_results();
        // Values above the table saturate to the last entry.
        set_zone(ZONE_ALL_ONES);
        send_stamp(stamp_of(2000, 1, 31, 12, 0, 0), 32'h9999_9999);
        drain_results();
        // Half-hour zones either side of UTC.
        set_zone(ZONE_UTC - 6'd1);
        send_stamp(stamp_of(2020, 6, 1, 0, 10, 0), 32'h0000_0400);
        drain_results();
        set_zone(ZONE_UTC + 6'd1);
        send_stamp(stamp_of(2020, 6, 30, 23, 45, 0), 32'h0000_03FF);
        drain_results();
    endtask

    // Random items over several zone settings and idling patterns.
    task automatic test_random_zones();
        logic [5:0] zones[6];
        int         burst;
        begin
            zones[0] = ZONE_WEST_END;
            zones[1] = ZONE_MAX;
            zones[2] = ZONE_ALL_ONES;
            zones[3] = 6'($urandom_range(47, 1));
            zones[4] = 6'($urandom_range(63, 0));
            zones[5] = ZONE_UTC;
            for (int phase = 0; phase < 6; phase++) begin
                set_zone(zones[phase]);
                sink_choppy = (phase % 2) == 1;
                burst = 0;
                repeat (140) begin
                    if (burst == 0) begin
                        burst = $urandom_range(24, 1);
                        if ((phase % 3) != 0)
                            pause_sender($urandom_range(8, 1));
                    end
                    send_random_stamp();
                    burst--;
                end
                drain_results();
            end
        end
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_output_stall();
        set_zone(6'($urandom_range(48, 0)));
        sink_choppy = 1'b0;
        sink_hold   = LONG_HOLD;
        repeat (60)
            send_random_stamp();
        drain_results();
    endtask

    // Receiver: ready in random runs, with short stalls when choppy, or a long hold-off on request.
    initial begin
        bit hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0 && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold - 1)
                    @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(11, 0))
                    @(negedge i_clk);
                if (sink_choppy) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(5, 0))
                        @(negedge i_clk);
                end
            end
        end
    end

    // Compare each result item with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_local_date want;
        t_date_word  got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (dates_due.size() == 0) begin
                report_mismatch("result item with no timestamp outstanding");
            end else begin
                want = dates_due.pop_front();
                check_field("valid_res", 32'(m_axis_tuser), 32'(want.valid));
                check_field("year_offset", 32'(got.year), 32'(want.word.year));
                check_field("month_num", 32'(got.month), 32'(want.word.month));
                check_field("day_num", 32'(got.day), 32'(want.word.day));
                check_field("hour_num", 32'(got.hour), 32'(want.word.hour));
                check_field("minute_num", 32'(got.minute), 32'(want.word.minute));
                check_field("second_num", 32'(got.second), 32'(want.word.second));
                check_field("micro_num", 32'(got.micro), 32'(want.word.micro));
                check_field("tdata padding", 32'(got.pad), 32'(want.word.pad));
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL ntp_timestamp_to_local_date");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        zone_setting  = ZONE_UTC;
        sink_choppy   = 1'b0;
        sink_hold     = 0;
        repeat (4)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_utc_edges();
        test_zone_rollovers();
        test_random_zones();
        test_output_stall();

        // Anything arriving now would have no prediction waiting.
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
        if (error_count == 0 && dates_due.size() == 0) begin
            $display("PASS ntp_timestamp_to_local_date");
        end else begin
            $display("FAIL ntp_timestamp_to_local_date");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/ntd_pkg.sv
hdl/ntd_epoch.sv
hdl/ntd_civil.sv
hdl/ntd_zone.sv
hdl/ntp_timestamp_to_local_date.sv
sim/ntp_timestamp_to_local_date_test.sv
